[hdl/swade_pkg.sv]
// ----------------------------------------------------------------------------
// swade_pkg
// Shared widths, command codes and reset values for the sensor window
// average and daily extremes block.
// ----------------------------------------------------------------------------
package swade_pkg;

  // field widths
  localparam int CMD_W  = 2;
  localparam int CO2_W  = 16;
  localparam int TEMP_W = 15;

  // default window length
  localparam int WINDOW_DEF = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WINDOW    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STATS     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DAY_RESET = 2'd2;

  // daily extremes after a daily reset
  localparam logic [CO2_W-1:0]         DAY_MAX_CO2_RST  = 16'd0;
  localparam logic signed [TEMP_W-1:0] DAY_MIN_TEMP_RST = 15'sd10000;
  localparam logic signed [TEMP_W-1:0] DAY_MAX_TEMP_RST = 15'sd0;

endpackage

[hdl/sensor_window_average_and_daily_extremes.sv]
// ----------------------------------------------------------------------------
// sensor_window_average_and_daily_extremes
// Window mean of CO2 and temperature over a ring of samples, plus daily CO2
// maximum and daily temperature range.
// ----------------------------------------------------------------------------
//
//  channel  | signals                      | payload
//  ---------+------------------------------+-----------------------------------
//  input    | in_valid_i / in_ready_o      | command, co2 and temp readings
//  output   | out_valid_o / out_ready_i    | means, daily extremes, valid flags
//
//  One transaction per cycle sustained while out_ready_i is high; a result is
//  built by the ring/sum update into the pipe register and then the divide-by-window
//  multiply into the output register.
//  Reset presets ring valid bits, sums, position, extremes at once; no clearing pass.
//  A stalled output holds the pipe; in_ready_o drops only when both stages
//  are full and out_ready_i is low.
//
module sensor_window_average_and_daily_extremes #(
  parameter int WINDOW = swade_pkg::WINDOW_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [swade_pkg::CMD_W-1:0]        command_i,
  input  logic [swade_pkg::CO2_W-1:0]        co2_ppm_i,
  input  logic                               co2_present_i,
  input  logic signed [swade_pkg::TEMP_W-1:0] temp_centi_i,
  input  logic                               temp_present_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [swade_pkg::CO2_W-1:0]        co2_average_o,
  output logic                               co2_average_valid_o,
  output logic signed [swade_pkg::TEMP_W-1:0] temp_average_o,
  output logic                               temp_average_valid_o,
  output logic [swade_pkg::CO2_W-1:0]        max_co2_o,
  output logic                               max_co2_valid_o,
  output logic signed [swade_pkg::TEMP_W-1:0] min_temp_o,
  output logic signed [swade_pkg::TEMP_W-1:0] max_temp_o,
  output logic                               temp_extremes_valid_o
);

  localparam int CW  = swade_pkg::CO2_W;
  localparam int TW  = swade_pkg::TEMP_W;
  localparam int L   = $clog2(WINDOW);
  localparam int PW  = (L < 1) ? 1 : L;
  localparam int CSW = CW + L;        // co2 sum width
  localparam int TSW = TW + L;        // temp sum width (signed)

  // floor divide by WINDOW: (x * ceil(2^k / WINDOW)) >> k, exact for x < 2^n
  localparam int CK  = CSW + L;
  localparam int CMW = CSW + 2;
  localparam logic [63:0] CM64 = ((64'd1 << CK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [CMW-1:0] CM = CMW'(CM64);
  localparam int TK  = TSW + L;
  localparam int TMW = TSW + 2;
  localparam logic [63:0] TM64 = ((64'd1 << TK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [TMW-1:0] TM = TMW'(TM64);
  // bias making the temp sum non-negative before division
  localparam logic [TSW-1:0] TOFF = TSW'(WINDOW * (2 ** (TW - 1)));
  localparam logic [CW-1:0]  TUNBIAS = CW'(2 ** (TW - 1));
  localparam logic [PW-1:0]  POS_LAST = PW'(WINDOW - 1);

  // pipe stage between the state update and the divide
  typedef struct packed {
    logic                 co2_avg_vld;
    logic                 temp_avg_vld;
    logic                 max_co2_vld;
    logic                 temp_ext_vld;
    logic [CSW-1:0]       co2_sum;
    logic [TSW-1:0]       temp_ubias;
    logic [CW-1:0]        max_co2;
    logic signed [TW-1:0] min_temp;
    logic signed [TW-1:0] max_temp;
  } pipe_t;

  logic accept;
  logic adv2;
  logic v1_q, v1_d;
  logic v2_q, v2_d;
  pipe_t pipe_q, pipe_d;

  logic is_window, is_stats, is_day_reset;
  logic co2_wr, temp_wr;

  logic [PW-1:0] pos_q, pos_d;

  logic [CW-1:0] co2_mem [WINDOW];
  logic [TW-1:0] temp_mem [WINDOW];
  logic [CW-1:0] co2_rd_q;
  logic [TW-1:0] temp_rd_q;
  logic [WINDOW-1:0] co2_vld_q, temp_vld_q;
  logic [CW-1:0] co2_old;
  logic [TW-1:0] temp_old;

  logic [CSW-1:0]        co2_sum_q, co2_sum_d;
  logic signed [TSW-1:0] temp_sum_q, temp_sum_d;

  logic [CW-1:0]        day_max_co2_q, day_max_co2_d;
  logic signed [TW-1:0] day_min_temp_q, day_min_temp_d;
  logic signed [TW-1:0] day_max_temp_q, day_max_temp_d;

  logic [CSW+CMW-1:0] co2_prod;
  logic [TSW+TMW-1:0] temp_prod;
  logic [CW-1:0]      temp_q16;

  logic [CW-1:0]        co2_avg_q;
  logic                 co2_avg_vld_q;
  logic signed [TW-1:0] temp_avg_q;
  logic                 temp_avg_vld_q;
  logic [CW-1:0]        max_co2_q;
  logic                 max_co2_vld_q;
  logic signed [TW-1:0] min_temp_q;
  logic signed [TW-1:0] max_temp_q;
  logic                 temp_ext_vld_q;

  // handshake and pipe occupancy
  assign adv2       = v1_q && (!v2_q || out_ready_i);
  assign in_ready_o = !v1_q || adv2;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    v1_d = v1_q;
    if (accept) begin
      v1_d = 1'b1;
    end else if (adv2) begin
      v1_d = 1'b0;
    end
    v2_d = v2_q;
    if (adv2) begin
      v2_d = 1'b1;
    end else if (out_ready_i) begin
      v2_d = 1'b0;
    end
  end

  // command decode
  always_comb begin
    is_window    = 1'b0;
    is_stats     = 1'b0;
    is_day_reset = 1'b0;
    case (command_i)
      swade_pkg::CMD_WINDOW:    is_window    = accept;
      swade_pkg::CMD_STATS:     is_stats     = accept;
      swade_pkg::CMD_DAY_RESET: is_day_reset = accept;
      default: ;
    endcase
  end

  assign co2_wr  = is_window && co2_present_i;
  assign temp_wr = is_window && temp_present_i;

  // ring position, advances on every window transaction
  always_comb begin
    pos_d = pos_q;
    if (is_window) begin
      pos_d = (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
    end
  end

  // ring memories; the slot at the next position is prefetched every cycle
  always_ff @(posedge clk_i) begin
    if (co2_wr) begin
      co2_mem[pos_q] <= co2_ppm_i;
    end
    if (temp_wr) begin
      temp_mem[pos_q] <= temp_centi_i;
    end
    co2_rd_q  <= co2_mem[pos_d];
    temp_rd_q <= temp_mem[pos_d];
  end

  // slots never written read as zero
  assign co2_old  = co2_vld_q[pos_q]  ? co2_rd_q  : '0;
  assign temp_old = temp_vld_q[pos_q] ? temp_rd_q : '0;

  // running sums
  always_comb begin
    co2_sum_d  = co2_sum_q;
    temp_sum_d = temp_sum_q;
    if (co2_wr) begin
      co2_sum_d = co2_sum_q + {{L{1'b0}}, co2_ppm_i} - {{L{1'b0}}, co2_old};
    end
    if (temp_wr) begin
      temp_sum_d = temp_sum_q + {{L{temp_centi_i[TW-1]}}, temp_centi_i}
                   - {{L{temp_old[TW-1]}}, temp_old};
    end
  end

  // daily extremes
  always_comb begin
    day_max_co2_d  = day_max_co2_q;
    day_min_temp_d = day_min_temp_q;
    day_max_temp_d = day_max_temp_q;
    if (is_day_reset) begin
      day_max_co2_d  = swade_pkg::DAY_MAX_CO2_RST;
      day_min_temp_d = swade_pkg::DAY_MIN_TEMP_RST;
      day_max_temp_d = swade_pkg::DAY_MAX_TEMP_RST;
    end else if (is_stats) begin
      if (co2_present_i && (co2_ppm_i > day_max_co2_q)) begin
        day_max_co2_d = co2_ppm_i;
      end
      if (temp_present_i) begin
        if (temp_centi_i < day_min_temp_q) begin
          day_min_temp_d = temp_centi_i;
        end
        if (temp_centi_i > day_max_temp_q) begin
          day_max_temp_d = temp_centi_i;
        end
      end
    end
  end

  // snapshot for the divide stage
  always_comb begin
    pipe_d.co2_avg_vld  = co2_wr;
    pipe_d.temp_avg_vld = temp_wr;
    pipe_d.max_co2_vld  = is_stats && co2_present_i;
    pipe_d.temp_ext_vld = is_stats && temp_present_i;
    pipe_d.co2_sum      = co2_sum_d;
    pipe_d.temp_ubias   = temp_sum_d + TOFF;
    pipe_d.max_co2      = day_max_co2_d;
    pipe_d.min_temp     = day_min_temp_d;
    pipe_d.max_temp     = day_max_temp_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      pos_q          <= '0;
      co2_vld_q      <= '0;
      temp_vld_q     <= '0;
      co2_sum_q      <= '0;
      temp_sum_q     <= '0;
      day_max_co2_q  <= swade_pkg::DAY_MAX_CO2_RST;
      day_min_temp_q <= swade_pkg::DAY_MIN_TEMP_RST;
      day_max_temp_q <= swade_pkg::DAY_MAX_TEMP_RST;
    end else begin
      v1_q           <= v1_d;
      v2_q           <= v2_d;
      pos_q          <= pos_d;
      co2_sum_q      <= co2_sum_d;
      temp_sum_q     <= temp_sum_d;
      day_max_co2_q  <= day_max_co2_d;
      day_min_temp_q <= day_min_temp_d;
      day_max_temp_q <= day_max_temp_d;
      if (co2_wr) begin
        co2_vld_q[pos_q] <= 1'b1;
      end
      if (temp_wr) begin
        temp_vld_q[pos_q] <= 1'b1;
      end
    end
  end

  // pipe payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pipe_q <= pipe_d;
    end
  end

  // divide by window through reciprocal multiply
  assign co2_prod  = {{CMW{1'b0}}, pipe_q.co2_sum} * {{CSW{1'b0}}, CM};
  assign temp_prod = {{TMW{1'b0}}, pipe_q.temp_ubias} * {{TSW{1'b0}}, TM};
  assign temp_q16  = temp_prod[TK +: CW] - TUNBIAS;

  // output register, unpublished fields forced to zero
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      co2_avg_vld_q  <= pipe_q.co2_avg_vld;
      temp_avg_vld_q <= pipe_q.temp_avg_vld;
      max_co2_vld_q  <= pipe_q.max_co2_vld;
      temp_ext_vld_q <= pipe_q.temp_ext_vld;
      co2_avg_q      <= pipe_q.co2_avg_vld  ? co2_prod[CK +: CW] : '0;
      temp_avg_q     <= pipe_q.temp_avg_vld ? temp_q16[TW-1:0]   : '0;
      max_co2_q      <= pipe_q.max_co2_vld  ? pipe_q.max_co2     : '0;
      min_temp_q     <= pipe_q.temp_ext_vld ? pipe_q.min_temp    : '0;
      max_temp_q     <= pipe_q.temp_ext_vld ? pipe_q.max_temp    : '0;
    end
  end

  assign out_valid_o           = v2_q;
  assign co2_average_o         = co2_avg_q;
  assign co2_average_valid_o   = co2_avg_vld_q;
  assign temp_average_o        = temp_avg_q;
  assign temp_average_valid_o  = temp_avg_vld_q;
  assign max_co2_o             = max_co2_q;
  assign max_co2_valid_o       = max_co2_vld_q;
  assign min_temp_o            = min_temp_q;
  assign max_temp_o            = max_temp_q;
  assign temp_extremes_valid_o = temp_ext_vld_q;

endmodule

[hdl/swade_chk.sv]
// ----------------------------------------------------------------------------
// swade_chk
// Port-level checks for the sensor window average and daily extremes block.
// ----------------------------------------------------------------------------
module swade_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [swade_pkg::CO2_W-1:0]         co2_average_o,
  input logic                                co2_average_valid_o,
  input logic signed [swade_pkg::TEMP_W-1:0] temp_average_o,
  input logic                                temp_average_valid_o,
  input logic [swade_pkg::CO2_W-1:0]         max_co2_o,
  input logic                                max_co2_valid_o,
  input logic signed [swade_pkg::TEMP_W-1:0] min_temp_o,
  input logic signed [swade_pkg::TEMP_W-1:0] max_temp_o,
  input logic                                temp_extremes_valid_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(co2_average_o)
      && $stable(temp_average_o) && $stable(max_co2_o))
  else $error("stalled result changed");

  // input side never blocks while the output side can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
  else $error("input stalled with free output");

  // window means and daily stats never come from the same transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((co2_average_valid_o || temp_average_valid_o)
      && (max_co2_valid_o || temp_extremes_valid_o)))
  else $error("mean and stats published together");

  // unpublished fields read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !co2_average_valid_o && !temp_average_valid_o
      && !max_co2_valid_o |-> co2_average_o == '0 && temp_average_o == '0
      && max_co2_o == '0)
  else $error("unpublished field not zero");

  // temperature extremes zero unless published
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !temp_extremes_valid_o |-> min_temp_o == '0 && max_temp_o == '0)
  else $error("unpublished extremes not zero");

endmodule

bind sensor_window_average_and_daily_extremes swade_chk u_swade_chk (.*);

[sim/sensor_extremes_checker.sv]
// ----------------------------------------------------------------------------
// sensor_extremes_checker
// Watches both channels of the sensor window average and daily extremes
// block, predicts every result from the accepted transactions and compares
// the results field by field in arrival order.
// ----------------------------------------------------------------------------
module sensor_extremes_checker
  import swade_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [CO2_W-1:0]         co2_ppm_i,
  input  logic                     co2_present_i,
  input  logic signed [TEMP_W-1:0] temp_centi_i,
  input  logic                     temp_present_i,
  // output channel
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [CO2_W-1:0]         co2_average_i,
  input  logic                     co2_average_valid_i,
  input  logic signed [TEMP_W-1:0] temp_average_i,
  input  logic                     temp_average_valid_i,
  input  logic [CO2_W-1:0]         max_co2_i,
  input  logic                     max_co2_valid_i,
  input  logic signed [TEMP_W-1:0] min_temp_i,
  input  logic signed [TEMP_W-1:0] max_temp_i,
  input  logic                     temp_extremes_valid_i,
  // status for the testbench top
  output int                       mismatches_o,
  output int                       pending_o,
  output int                       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = WINDOW_DEF;

  typedef struct packed {
    logic [CO2_W-1:0]         co2_average;
    logic                     co2_average_valid;
    logic signed [TEMP_W-1:0] temp_average;
    logic                     temp_average_valid;
    logic [CO2_W-1:0]         max_co2;
    logic                     max_co2_valid;
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic                     temp_extremes_valid;
  } sensor_result_t;

  // predicted block state
  logic [CO2_W-1:0]         co2_slots [WIN];
  logic signed [TEMP_W-1:0] temp_slots [WIN];
  int                       next_slot;
  int                       co2_total;
  int                       temp_total;
  logic [CO2_W-1:0]         peak_co2;
  logic signed [TEMP_W-1:0] low_temp;
  logic signed [TEMP_W-1:0] high_temp;

  sensor_result_t expected_results [$];

  // work out the result of one transaction and advance the predicted state
  function automatic sensor_result_t predict_result(
    logic [CMD_W-1:0]         cmd,
    logic [CO2_W-1:0]         co2,
    logic                     co2_ok,
    logic signed [TEMP_W-1:0] temp,
    logic                     temp_ok
  );
    sensor_result_t r;
    int             mean;
    r = '0;
    case (cmd)
      CMD_WINDOW: begin
        if (co2_ok) begin
          co2_total = co2_total - int'(co2_slots[next_slot]) + int'(co2);
          co2_slots[next_slot] = co2;
          r.co2_average = CO2_W'(co2_total / WIN);
          r.co2_average_valid = 1'b1;
        end
        if (temp_ok) begin
          temp_total = temp_total - int'(temp_slots[next_slot]) + int'(temp);
          temp_slots[next_slot] = temp;
          // mean rounds toward minus infinity
          mean = temp_total / WIN;
          if ((temp_total % WIN) != 0 && temp_total < 0) begin
            mean = mean - 1;
          end
          r.temp_average = TEMP_W'(mean);
          r.temp_average_valid = 1'b1;
        end
        // position moves on even when neither sample is valid
        next_slot = (next_slot + 1) % WIN;
      end
      CMD_STATS: begin
        if (co2_ok) begin
          if (co2 > peak_co2) begin
            peak_co2 = co2;
          end
          r.max_co2 = peak_co2;
          r.max_co2_valid = 1'b1;
        end
        if (temp_ok) begin
          if (temp < low_temp) begin
            low_temp = temp;
          end
          if (temp > high_temp) begin
            high_temp = temp;
          end
          r.min_temp = low_temp;
          r.max_temp = high_temp;
          r.temp_extremes_valid = 1'b1;
        end
      end
      CMD_DAY_RESET: begin
        peak_co2  = DAY_MAX_CO2_RST;
        low_temp  = DAY_MIN_TEMP_RST;
        high_temp = DAY_MAX_TEMP_RST;
      end
      default: begin
        // unused command leaves everything alone and publishes nothing
      end
    endcase
    return r;
  endfunction

  // report one field, returns 1 on a mismatch
  function automatic int field_mismatch(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // track transactions on both channels
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sensor_result_t want;
    sensor_result_t got;
    int             i;
    if (!rst_ni) begin
      for (i = 0; i < WIN; i++) begin
        co2_slots[i]  = '0;
        temp_slots[i] = '0;
      end
      next_slot    = 0;
      co2_total    = 0;
      temp_total   = 0;
      peak_co2     = DAY_MAX_CO2_RST;
      low_temp     = DAY_MIN_TEMP_RST;
      high_temp    = DAY_MAX_TEMP_RST;
      expected_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // result transaction against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got.co2_average         = co2_average_i;
        got.co2_average_valid   = co2_average_valid_i;
        got.temp_average        = temp_average_i;
        got.temp_average_valid  = temp_average_valid_i;
        got.max_co2             = max_co2_i;
        got.max_co2_valid       = max_co2_valid_i;
        got.min_temp            = min_temp_i;
        got.max_temp            = max_temp_i;
        got.temp_extremes_valid = temp_extremes_valid_i;
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          mismatches_o += field_mismatch("co2_average",
            want.co2_average, got.co2_average);
          mismatches_o += field_mismatch("co2_average_valid",
            want.co2_average_valid, got.co2_average_valid);
          mismatches_o += field_mismatch("temp_average",
            $signed(want.temp_average), $signed(got.temp_average));
          mismatches_o += field_mismatch("temp_average_valid",
            want.temp_average_valid, got.temp_average_valid);
          mismatches_o += field_mismatch("max_co2",
            want.max_co2, got.max_co2);
          mismatches_o += field_mismatch("max_co2_valid",
            want.max_co2_valid, got.max_co2_valid);
          mismatches_o += field_mismatch("min_temp",
            $signed(want.min_temp), $signed(got.min_temp));
          mismatches_o += field_mismatch("max_temp",
            $signed(want.max_temp), $signed(got.max_temp));
          mismatches_o += field_mismatch("temp_extremes_valid",
            want.temp_extremes_valid, got.temp_extremes_valid);
          checked_o++;
        end
      end
      // input transaction queues its prediction
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_result(command_i, co2_ppm_i, co2_present_i,
                                                  temp_centi_i, temp_present_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[sim/tb_sensor_window_average_and_daily_extremes.sv]
// ----------------------------------------------------------------------------
// tb_sensor_window_average_and_daily_extremes
// Drives directed and random sensor transactions with bursty input and a
// stalling output, including long output hold-offs, and leaves all result
// checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_sensor_window_average_and_daily_extremes;
  import swade_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 64;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [CMD_W-1:0]         command_i = CMD_WINDOW;
  logic [CO2_W-1:0]         co2_ppm_i = '0;
  logic                     co2_present_i = 1'b0;
  logic signed [TEMP_W-1:0] temp_centi_i = '0;
  logic                     temp_present_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [CO2_W-1:0]         co2_average_o;
  logic                     co2_average_valid_o;
  logic signed [TEMP_W-1:0] temp_average_o;
  logic                     temp_average_valid_o;
  logic [CO2_W-1:0]         max_co2_o;
  logic                     max_co2_valid_o;
  logic signed [TEMP_W-1:0] min_temp_o;
  logic signed [TEMP_W-1:0] max_temp_o;
  logic                     temp_extremes_valid_o;

  int mismatches;
  int pending;
  int checked;

  // long output hold-offs asked by the sender, served by the receiver
  int hold_requests = 0;
  int hold_served = 0;

  // transactions per command
  int command_count [4] = '{0, 0, 0, 0};

  sensor_window_average_and_daily_extremes dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .command_i            (command_i),
    .co2_ppm_i            (co2_ppm_i),
    .co2_present_i        (co2_present_i),
    .temp_centi_i         (temp_centi_i),
    .temp_present_i       (temp_present_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .co2_average_o        (co2_average_o),
    .co2_average_valid_o  (co2_average_valid_o),
    .temp_average_o       (temp_average_o),
    .temp_average_valid_o (temp_average_valid_o),
    .max_co2_o            (max_co2_o),
    .max_co2_valid_o      (max_co2_valid_o),
    .min_temp_o           (min_temp_o),
    .max_temp_o           (max_temp_o),
    .temp_extremes_valid_o(temp_extremes_valid_o)
  );

  sensor_extremes_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .command_i            (command_i),
    .co2_ppm_i            (co2_ppm_i),
    .co2_present_i        (co2_present_i),
    .temp_centi_i         (temp_centi_i),
    .temp_present_i       (temp_present_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .co2_average_i        (co2_average_o),
    .co2_average_valid_i  (co2_average_valid_o),
    .temp_average_i       (temp_average_o),
    .temp_average_valid_i (temp_average_valid_o),
    .max_co2_i            (max_co2_o),
    .max_co2_valid_i      (max_co2_valid_o),
    .min_temp_i           (min_temp_o),
    .max_temp_i           (max_temp_o),
    .temp_extremes_valid_i(temp_extremes_valid_o),
    .mismatches_o         (mismatches),
    .pending_o            (pending),
    .checked_o            (checked)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout: results still outstanding at %0t ns", $time);
    $display("*** FAILED ***");
    $finish;
  end

  // offer one transaction and hold it until accepted
  task automatic offer_reading(logic [CMD_W-1:0] cmd, logic [CO2_W-1:0] co2, logic co2_ok,
                               logic signed [TEMP_W-1:0] temp, logic temp_ok);
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    co2_ppm_i      <= co2;
    co2_present_i  <= co2_ok;
    temp_centi_i   <= temp;
    temp_present_i <= temp_ok;
    do @(posedge clk_i); while (!in_ready_o);
    command_count[cmd]++;
  endtask

  // co2 reading: mostly in range, some full width and edge values
  function automatic logic [CO2_W-1:0] pick_co2();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return CO2_W'($urandom_range(0, 40000));
    if (sel < 17) return CO2_W'($urandom);
    if (sel == 17) return '1;
    if (sel == 18) return CO2_W'(40000);
    return '0;
  endfunction

  // temperature reading: mostly in range, some full width and edge values
  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return TEMP_W'(int'($urandom_range(0, 14000)) - 4000);
    if (sel < 17) return TEMP_W'($urandom);
    if (sel == 17) return TEMP_W'(-16384);
    if (sel == 18) return TEMP_W'(16383);
    return TEMP_W'(-4000);
  endfunction

  // receiver: changing stall patterns plus long hold-offs on request
  initial begin : receiver
    int cyc;
    int stall_left;
    cyc = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_served) begin
        hold_served++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((cyc / 256) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 4) != 0);
          default: out_ready_i <= ((cyc % 5) > 1);
        endcase
      end
      cyc++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int               n;
    int               i;
    int               gap;
    int               burst_left;
    int               sel;
    logic [CMD_W-1:0] cmd;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window samples at the field extremes
    offer_reading(CMD_WINDOW, '1, 1'b1, TEMP_W'(-16384), 1'b1);
    offer_reading(CMD_WINDOW, '0, 1'b1, TEMP_W'(16383), 1'b1);
    offer_reading(CMD_WINDOW, CO2_W'(40000), 1'b1, TEMP_W'(10000), 1'b1);
    // one channel invalid, then both invalid: position still advances
    offer_reading(CMD_WINDOW, CO2_W'(1234), 1'b1, TEMP_W'(500), 1'b0);
    offer_reading(CMD_WINDOW, CO2_W'(999), 1'b0, TEMP_W'(-4000), 1'b1);
    offer_reading(CMD_WINDOW, '1, 1'b0, TEMP_W'(16383), 1'b0);
    // stats at the extremes, then with channels absent
    offer_reading(CMD_STATS, '1, 1'b1, TEMP_W'(-16384), 1'b1);
    offer_reading(CMD_STATS, CO2_W'(500), 1'b1, TEMP_W'(16383), 1'b1);
    offer_reading(CMD_STATS, CO2_W'(400), 1'b1, TEMP_W'(0), 1'b0);
    offer_reading(CMD_STATS, CO2_W'(400), 1'b0, TEMP_W'(2000), 1'b1);
    offer_reading(CMD_STATS, '0, 1'b0, '0, 1'b0);
    // daily reset, then values on either side of the reset extremes
    offer_reading(CMD_DAY_RESET, '1, 1'b1, TEMP_W'(-1), 1'b1);
    offer_reading(CMD_STATS, CO2_W'(1), 1'b1, TEMP_W'(12000), 1'b1);
    offer_reading(CMD_DAY_RESET, '0, 1'b0, '0, 1'b0);
    offer_reading(CMD_STATS, '0, 1'b1, TEMP_W'(-1), 1'b1);
    // unused command with every bit set
    offer_reading(CMD_UNUSED, '1, 1'b1, TEMP_W'(-1), 1'b1);
    // a full ring of small negative samples for the floor of the mean
    for (i = 0; i < 8; i++) begin
      offer_reading(CMD_WINDOW, CO2_W'(i), 1'b1, TEMP_W'(-1 - i), 1'b1);
    end

    // random transactions in bursts
    burst_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200 || n == 800) begin
        // keep offering back to back while the output is held off
        hold_requests++;
        burst_left = 40;
      end else if (burst_left == 0 && !(n >= 1000 && n < 1150)) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 32);
      end
      if (burst_left > 0) begin
        burst_left--;
      end
      sel = $urandom_range(0, 99);
      if (sel < 60) cmd = CMD_WINDOW;
      else if (sel < 85) cmd = CMD_STATS;
      else if (sel < 93) cmd = CMD_DAY_RESET;
      else cmd = CMD_UNUSED;
      offer_reading(cmd, pick_co2(), ($urandom_range(0, 9) != 0),
                    pick_temp(), ($urandom_range(0, 9) != 0));
    end
    in_valid_i <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d window, %0d stats, %0d daily reset, %0d unused-command transactions",
             command_count[CMD_WINDOW], command_count[CMD_STATS],
             command_count[CMD_DAY_RESET], command_count[CMD_UNUSED]);
    $display("%0d results compared, %0d output hold-offs, %0d mismatching fields",
             checked, hold_served, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
